// ----- hdl/psom_pkg.sv -----
// shared types and constants for the second-order pdm modulator
`timescale 1ns / 1ps

package psom_pkg;

    localparam logic [31:0] INPUT_OFFSET = 32'h0000_1000;
    localparam logic [31:0] IDLE_PATTERN = 32'h5555_5555;

    // feedback held as a 25-bit two's complement value
    localparam int          FB_W   = 25;
    localparam logic [24:0] FB_POS = 25'h0FE_DCBA;
    localparam logic [24:0] FB_NEG = 25'h101_2346;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam int        CFG_IDX_W      = 1;
    localparam int        CFG_DATA_W     = 5;
    localparam logic [0:0] CFG_FORMAT     = 1'b0;
    localparam logic [0:0] CFG_OVERSAMPLE = 1'b1;

    typedef struct packed {
        logic [31:0] x;
        logic        idle;
    } t_job;

    typedef struct packed {
        logic busy;
        logic idle_job;
    } t_back_status;

endpackage

// ----- hdl/pdm_second_order_modulator_unit.sv -----
// top level of the second-order delta-sigma pdm modulator
//
//  channel   dir  handshake              payload
//  s_axis    in   i_s_tvalid/o_s_tready  tdata = sample_bits, tuser = no_source
//  m_axis    out  o_m_tvalid/i_m_tready  tdata = pdm_word, tlast = last_of_run
//  cfg       in   i_cfg_we               index 0 format_is_u8, 1 oversample_factor
//
// the loop makes one integrator update per cycle while it is not held, one pdm bit per update and
// n words per sample; a no-source item gives n idle-pattern words. each job is loaded before it runs.
// the input stage and a two-entry queue keep taking samples while the loop runs.
// synchronous active-low reset clears the integrators, feedback, config and all valids.
// a full output register holds the loop on the last bit of a word until it drains.
`timescale 1ns / 1ps

module pdm_second_order_modulator_unit #(
    parameter int MAX_OVERSAMPLE = 16,
    parameter int BITS_PER_WORD  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [15:0]                     i_s_tdata,   // sample_bits
    input  logic                            i_s_tuser,   // no_source
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [31:0]                     o_m_tdata,   // pdm_word
    output logic                            o_m_tlast,
    input  logic                            i_cfg_we,
    input  logic [psom_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psom_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psom_pkg::*;

    localparam int CNT_W = $clog2(MAX_OVERSAMPLE + 1);

    logic                  r_fmt_u8;
    logic [4:0]            r_oversample;
    logic [CNT_W-1:0]      w_words;
    t_job                  w_f_job;
    logic                  w_f_valid;
    logic                  w_f_ready;
    t_job                  w_q_job;
    logic                  w_q_valid;
    logic                  w_q_ready;
    t_back_status          w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt_u8     <= 1'b0;
            r_oversample <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FORMAT:     r_fmt_u8     <= i_cfg_data[0];
                CFG_OVERSAMPLE: r_oversample <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // zero counts as one, large values saturate
    always_comb begin
        if (r_oversample == '0) begin
            w_words = CNT_W'(1);
        end else if (int'(r_oversample) > MAX_OVERSAMPLE) begin
            w_words = CNT_W'(MAX_OVERSAMPLE);
        end else begin
            w_words = CNT_W'(r_oversample);
        end
    end

    psom_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fmt_u8      (r_fmt_u8),
        .i_sample_bits (i_s_tdata),
        .i_no_source   (i_s_tuser),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .o_job         (w_f_job),
        .o_job_valid   (w_f_valid),
        .i_job_ready   (w_f_ready)
    );

    psom_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_f_job),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .o_job   (w_q_job),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready)
    );

    psom_back #(
        .BITS_PER_WORD (BITS_PER_WORD),
        .CNT_W         (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_q_job),
        .i_job_valid (w_q_valid),
        .o_job_ready (w_q_ready),
        .i_words     (w_words),
        .o_pdm_word  (o_m_tdata),
        .o_last      (o_m_tlast),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_status    (w_stat)
    );

    // a queued job is picked up as soon as the loop is free
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid && !w_stat.busy |=> w_stat.busy)
        else $error("queued job not loaded by free loop");

    // a no-source job delivers a word every cycle the output can take one
    a_idle_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy && w_stat.idle_job && !(o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("idle pattern word not produced");

    // results only come out of a running job
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_stat.busy))
        else $error("output beat without an active job");

endmodule

// ----- hdl/psom_front.sv -----
// input stage: widens the sample and registers one job for the queue
`timescale 1ns / 1ps

module psom_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fmt_u8,
    input  logic [15:0]      i_sample_bits,
    input  logic             i_no_source,
    input  logic             i_valid,
    output logic             o_ready,
    output psom_pkg::t_job   o_job,
    output logic             o_job_valid,
    input  logic             i_job_ready
);
    import psom_pkg::*;

    logic        r_valid;
    logic        n_valid;
    t_job        r_job;
    logic [15:0] w_s16;
    t_job        w_job;
    logic        w_take;

    // u8: (b - 128) << 8 is the byte with its top bit flipped, in the high byte
    always_comb begin
        if (i_fmt_u8) begin
            w_s16 = {~i_sample_bits[7], i_sample_bits[6:0], 8'h00};
        end else begin
            w_s16 = i_sample_bits;
        end
        w_job.x    = {{8{w_s16[15]}}, w_s16, 8'h00} + INPUT_OFFSET;
        w_job.idle = i_no_source;
    end

    assign o_ready     = !r_valid || i_job_ready;
    assign w_take      = i_valid && o_ready;
    assign o_job       = r_job;
    assign o_job_valid = r_valid;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_job_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job <= w_job;
        end
    end

endmodule

// ----- hdl/psom_fifo.sv -----
// two-entry job queue between the input stage and the loop
`timescale 1ns / 1ps

module psom_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  psom_pkg::t_job i_job,
    input  logic           i_valid,
    output logic           o_ready,
    output psom_pkg::t_job o_job,
    output logic           o_valid,
    input  logic           i_ready
);
    import psom_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = r_count != (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- hdl/psom_back.sv -----
// delta-sigma loop with the output register, one pdm bit per cycle unless a full output register holds it
`timescale 1ns / 1ps

module psom_back #(
    parameter int BITS_PER_WORD = 32,
    parameter int CNT_W         = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  psom_pkg::t_job         i_job,
    input  logic                   i_job_valid,
    output logic                   o_job_ready,
    input  logic [CNT_W-1:0]       i_words,
    output logic [31:0]            o_pdm_word,
    output logic                   o_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output psom_pkg::t_back_status o_status
);
    import psom_pkg::*;

    localparam int                 BIT_W    = $clog2(BITS_PER_WORD);
    localparam logic [BIT_W-1:0]   LAST_BIT = BIT_W'(BITS_PER_WORD - 1);

    logic                     r_busy,  n_busy;
    logic [CNT_W-1:0]         r_left,  n_left;
    logic [BIT_W-1:0]         r_bit,   n_bit;
    logic [31:0]              r_i1,    n_i1;
    logic [31:0]              r_i2,    n_i2;
    logic [FB_W-1:0]          r_fb,    n_fb;
    logic                     r_out_valid, n_out_valid;
    logic [31:0]              r_out_word,  n_out_word;
    logic                     r_out_last,  n_out_last;
    logic [31:0]              r_x;
    logic                     r_idle;
    logic [BITS_PER_WORD-1:0] r_word,  n_word;

    logic                     w_load;
    logic                     w_can_push;
    logic                     w_word_end;
    logic                     w_step;
    logic                     w_push;
    logic [31:0]              w_fb_ext;
    logic [31:0]              w_i1;
    logic [31:0]              w_i2;
    logic                     w_bit;
    logic [BITS_PER_WORD-1:0] w_shift;

    assign o_job_ready = !r_busy;
    assign w_load      = !r_busy && i_job_valid;
    assign w_can_push  = !r_out_valid || i_ready;
    assign w_word_end  = r_idle || (r_bit == LAST_BIT);
    // the loop only holds on the bit that completes a word
    assign w_step      = r_busy && (!w_word_end || w_can_push);
    assign w_push      = w_step && w_word_end;

    assign w_fb_ext = {{(32-FB_W){r_fb[FB_W-1]}}, r_fb};
    assign w_i1     = r_i1 + r_x - w_fb_ext;
    assign w_i2     = r_i2 + w_i1 - w_fb_ext;
    assign w_bit    = ~w_i2[31];
    assign w_shift  = {w_bit, r_word[BITS_PER_WORD-1:1]};

    always_comb begin
        n_busy      = r_busy;
        n_left      = r_left;
        n_bit       = r_bit;
        n_i1        = r_i1;
        n_i2        = r_i2;
        n_fb        = r_fb;
        n_word      = r_word;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        n_out_last  = r_out_last;

        if (i_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_load) begin
            n_busy = 1'b1;
            n_left = i_words;
            n_bit  = '0;
        end

        if (w_step && !r_idle) begin
            n_i1   = w_i1;
            n_i2   = w_i2;
            n_fb   = w_bit ? FB_POS : FB_NEG;
            n_word = w_shift;
            n_bit  = r_bit + BIT_W'(1);
        end

        if (w_push) begin
            n_bit       = '0;
            n_out_valid = 1'b1;
            n_out_last  = r_left == CNT_W'(1);
            n_left      = r_left - CNT_W'(1);
            if (r_idle) begin
                n_out_word = 32'(IDLE_PATTERN[BITS_PER_WORD-1:0]);
            end else begin
                n_out_word = 32'(w_shift);
            end
            if (r_left == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_left      <= '0;
            r_bit       <= '0;
            r_i1        <= '0;
            r_i2        <= '0;
            r_fb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_left      <= n_left;
            r_bit       <= n_bit;
            r_i1        <= n_i1;
            r_i2        <= n_i2;
            r_fb        <= n_fb;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
        if (w_load) begin
            r_x    <= i_job.x;
            r_idle <= i_job.idle;
        end
    end

    assign o_pdm_word        = r_out_word;
    assign o_last            = r_out_last;
    assign o_valid           = r_out_valid;
    assign o_status.busy     = r_busy;
    assign o_status.idle_job = r_idle;

endmodule
